[hw/rtl/mctt_pkg.sv]
// ----------------------------------------------------------------------------
// MIDI clock tempo tracker package
// Shared constants and the request and response types of the serial divider.
// ----------------------------------------------------------------------------
package mctt_pkg;

  localparam logic [23:0] MAX24       = 24'hFFFFFF;
  localparam logic [31:0] MAX32       = 32'hFFFFFFFF;
  localparam logic [31:0] US_PER_MIN  = 32'd60000000;
  localparam logic [63:0] RAW_NUM     = 64'd15360000000;
  localparam logic [11:0] SEV_CAP     = 12'd2560;
  localparam logic [23:0] TEMPO_RESET = 24'd30720;

  // Division by ten: y * RECIP_TEN >> 35 is exact for y below 2^34, and
  // 2^32 = 10 * TEN_WORD_Q + 6 splits a wider dividend into two words.
  localparam logic [31:0] RECIP_TEN   = 32'hCCCCCCCD;
  localparam logic [28:0] TEN_WORD_Q  = 29'd429496729;
  localparam logic [63:0] VAR_SAT     = 64'd42949672960;

  localparam logic [1:0] REG_TPQ    = 2'd0;
  localparam logic [1:0] REG_SMOOTH = 2'd1;
  localparam logic [1:0] REG_FACTOR = 2'd2;
  localparam logic [1:0] REG_LIMIT  = 2'd3;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

endpackage

[hw/rtl/midi_clock_tempo_tracker.sv]
// ----------------------------------------------------------------------------
// MIDI clock tempo tracker
// Estimates tempo, tempo variance and timing drift from stamped clock ticks.
// ----------------------------------------------------------------------------
// Each input beat carries the microsecond arrival time of one MIDI clock tick
// and is taken when in_valid_i is high and in_stall_o is low. Each input beat
// gives exactly one output beat, held on the out ports until out_valid_o is
// high and out_stall_i is low. Configuration must be written through cfg_we_i,
// cfg_index_i and cfg_data_i while the block is idle; this is not enforced.
// A tick that starts a quarter-note cycle only records its time, and the
// sequencer goes straight to its last step to load the result. A measured
// tick runs a sequencer over one shared 32x32 multiplier and one 64-step
// serial divider; it uses up to three divisions. Divisions by ten use the
// multiplier. in_stall_o stays high while a tick is in work, and the next
// tick is taken in the cycle after the result is loaded at the earliest.
// When the receiver stalls, the previous result waits in the output register
// and the sequencer holds the new result in its last step until it is loaded.
// Reset restores the default registers, 120 BPM, and clears all statistics.
// ----------------------------------------------------------------------------
module midi_clock_tempo_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] arrival_time_us_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        measured_o,
  output logic [23:0] raw_tempo_q8_o,
  output logic [23:0] tempo_q8_o,
  output logic [23:0] drift_us_o,
  output logic [23:0] average_drift_us_o,
  output logic [23:0] peak_drift_us_o,
  output logic [31:0] tempo_variance_q8_o,
  output logic [31:0] measured_count_o,
  output logic        drift_alarm_o,
  output logic [11:0] severity_q8_o
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_ELAP  = 5'd1;
  localparam logic [4:0] ST_RDIV  = 5'd2;
  localparam logic [4:0] ST_RWAIT = 5'd3;
  localparam logic [4:0] ST_BR    = 5'd4;
  localparam logic [4:0] ST_SM1   = 5'd5;
  localparam logic [4:0] ST_SM2   = 5'd6;
  localparam logic [4:0] ST_SM3   = 5'd7;
  localparam logic [4:0] ST_SQ    = 5'd8;
  localparam logic [4:0] ST_V9    = 5'd9;
  localparam logic [4:0] ST_VDIV  = 5'd10;
  localparam logic [4:0] ST_VWAIT = 5'd11;
  localparam logic [4:0] ST_TSQ   = 5'd12;
  localparam logic [4:0] ST_DMUL  = 5'd13;
  localparam logic [4:0] ST_DDIV  = 5'd14;
  localparam logic [4:0] ST_DWAIT = 5'd15;
  localparam logic [4:0] ST_A9    = 5'd16;
  localparam logic [4:0] ST_ADIV  = 5'd17;
  localparam logic [4:0] ST_AWAIT = 5'd18;
  localparam logic [4:0] ST_SEV   = 5'd19;
  localparam logic [4:0] ST_SDIV  = 5'd20;
  localparam logic [4:0] ST_SWAIT = 5'd21;
  localparam logic [4:0] ST_FIN   = 5'd22;

  logic [4:0]  state_q, state_d;
  logic [6:0]  tpq_q, tpq_d;
  logic        smooth_q, smooth_d;
  logic [15:0] factor_q, factor_d;
  logic [23:0] limit_q, limit_d;

  logic [31:0] last_q, last_d;
  logic [6:0]  phase_q, phase_d;
  logic [23:0] tempo_q, tempo_d;
  logic [31:0] var_q, var_d;
  logic [23:0] avg_q, avg_d;
  logic [23:0] peak_q, peak_d;
  logic [31:0] count_q, count_d;

  logic [31:0] t_q, t_d;
  logic        meas_q, meas_d;
  logic [23:0] raw_q, raw_d;
  logic [23:0] drift_q, drift_d;
  logic        alarm_q, alarm_d;
  logic [11:0] sev_q, sev_d;
  logic [63:0] acc_q, acc_d;
  logic [39:0] sq_q, sq_d;
  logic [47:0] dsq_q, dsq_d;
  logic [63:0] prod_q, prod_d;
  logic [3:0]  vhi_q, vhi_d;
  logic        vcarry_q, vcarry_d;
  logic [31:0] mul_a, mul_b;

  logic        out_valid_q, out_valid_d;
  logic        o_meas_q;
  logic [23:0] o_raw_q, o_tempo_q, o_drift_q, o_avg_q, o_peak_q;
  logic [31:0] o_var_q, o_count_q;
  logic        o_alarm_q;
  logic [11:0] o_sev_q;
  logic        out_load;

  logic [23:0] diff;
  logic [63:0] quo;
  logic [64:0] smooth_sum;
  logic [63:0] ten_x;
  logic [32:0] ten_y;
  logic [64:0] ten_p;

  mctt_pkg::div_req_t div_req;
  mctt_pkg::div_rsp_t div_rsp;

  mctt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign quo        = div_rsp.quotient;
  assign diff       = (raw_q >= tempo_q) ? raw_q - tempo_q : tempo_q - raw_q;
  assign smooth_sum = {1'b0, acc_q} + {1'b0, prod_q} + 65'd32768;
  assign prod_d     = mul_a * mul_b;
  assign out_load   = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);

  always_comb begin
    tpq_d    = tpq_q;
    smooth_d = smooth_q;
    factor_d = factor_q;
    limit_d  = limit_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        mctt_pkg::REG_TPQ:    tpq_d    = cfg_data_i[6:0];
        mctt_pkg::REG_SMOOTH: smooth_d = cfg_data_i[0];
        mctt_pkg::REG_FACTOR: factor_d = cfg_data_i[15:0];
        mctt_pkg::REG_LIMIT:  limit_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d  = state_q;
    last_d   = last_q;
    phase_d  = phase_q;
    tempo_d  = tempo_q;
    var_d    = var_q;
    avg_d    = avg_q;
    peak_d   = peak_q;
    count_d  = count_q;
    t_d      = t_q;
    meas_d   = meas_q;
    raw_d    = raw_q;
    drift_d  = drift_q;
    alarm_d  = alarm_q;
    sev_d    = sev_q;
    acc_d    = acc_q;
    sq_d     = sq_q;
    dsq_d    = dsq_q;
    vhi_d    = vhi_q;
    vcarry_d = vcarry_q;
    ten_x    = '0;
    ten_y    = '0;
    ten_p    = '0;
    mul_a    = '0;
    mul_b    = '0;
    div_req  = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          t_d     = arrival_time_us_i;
          raw_d   = '0;
          drift_d = '0;
          alarm_d = 1'b0;
          sev_d   = '0;
          if (phase_q == 7'd0) begin
            last_d  = arrival_time_us_i;
            phase_d = 7'd1;
            meas_d  = 1'b0;
            state_d = ST_FIN;
          end else begin
            meas_d  = 1'b1;
            state_d = ST_ELAP;
          end
        end
      end
      ST_ELAP: begin
        mul_a   = t_q - last_q;
        mul_b   = {25'd0, tpq_q};
        state_d = ST_RDIV;
      end
      ST_RDIV: begin
        if (prod_q == 64'd0) begin
          raw_d   = mctt_pkg::MAX24;
          state_d = ST_BR;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = mctt_pkg::RAW_NUM + (prod_q >> 1);
          div_req.divisor  = prod_q;
          state_d          = ST_RWAIT;
        end
      end
      ST_RWAIT: begin
        if (div_rsp.done) begin
          raw_d   = (quo > 64'(mctt_pkg::MAX24)) ? mctt_pkg::MAX24 : quo[23:0];
          state_d = ST_BR;
        end
      end
      ST_BR: begin
        if (smooth_q) begin
          state_d = ST_SM1;
        end else begin
          tempo_d = raw_q;
          state_d = ST_TSQ;
        end
      end
      ST_SM1: begin
        mul_a   = {8'd0, tempo_q};
        mul_b   = 32'd65536 - {16'd0, factor_q};
        state_d = ST_SM2;
      end
      ST_SM2: begin
        acc_d   = prod_q;
        mul_a   = {8'd0, raw_q};
        mul_b   = {16'd0, factor_q};
        state_d = ST_SM3;
      end
      ST_SM3: begin
        tempo_d = smooth_sum[39:16];
        state_d = ST_SQ;
      end
      ST_SQ: begin
        mul_a   = {8'd0, diff};
        mul_b   = {8'd0, diff};
        state_d = ST_V9;
      end
      ST_V9: begin
        sq_d    = 40'((prod_q + 64'd128) >> 8);
        mul_a   = var_q;
        mul_b   = 32'd9;
        state_d = ST_VDIV;
      end
      ST_VDIV: begin
        ten_x = prod_q + {24'd0, sq_q} + 64'd5;
        if (ten_x >= mctt_pkg::VAR_SAT) begin
          var_d   = mctt_pkg::MAX32;
          state_d = ST_TSQ;
        end else begin
          ten_y    = {27'd0, ten_x[35:32], 2'b0} + {28'd0, ten_x[35:32], 1'b0}
                     + {1'b0, ten_x[31:0]};
          vhi_d    = ten_x[35:32];
          vcarry_d = ten_y[32];
          mul_a    = ten_y[31:0];
          mul_b    = mctt_pkg::RECIP_TEN;
          state_d  = ST_VWAIT;
        end
      end
      ST_VWAIT: begin
        ten_p   = {1'b0, prod_q} +
                  (vcarry_q ? {1'b0, mctt_pkg::RECIP_TEN, 32'd0} : 65'd0);
        var_d   = 32'(vhi_q * mctt_pkg::TEN_WORD_Q) + 32'(ten_p >> 35);
        state_d = ST_TSQ;
      end
      ST_TSQ: begin
        count_d = count_q + 32'd1;
        mul_a   = {8'd0, tempo_q};
        mul_b   = {8'd0, tempo_q};
        state_d = ST_DMUL;
      end
      ST_DMUL: begin
        dsq_d = prod_q[47:0];
        if (prod_q == 64'd0) begin
          drift_d = (diff != 24'd0) ? mctt_pkg::MAX24 : 24'd0;
          state_d = ST_A9;
        end else begin
          mul_a   = {8'd0, diff};
          mul_b   = mctt_pkg::US_PER_MIN;
          state_d = ST_DDIV;
        end
      end
      ST_DDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_q << 8;
        div_req.divisor  = {16'd0, dsq_q};
        state_d          = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_rsp.done) begin
          drift_d = (quo > 64'(mctt_pkg::MAX24)) ? mctt_pkg::MAX24 : quo[23:0];
          state_d = ST_A9;
        end
      end
      ST_A9: begin
        mul_a   = {8'd0, avg_q};
        mul_b   = 32'd9;
        state_d = ST_ADIV;
      end
      ST_ADIV: begin
        ten_x   = prod_q + {40'd0, drift_q} + 64'd5;
        mul_a   = ten_x[31:0];
        mul_b   = mctt_pkg::RECIP_TEN;
        state_d = ST_AWAIT;
      end
      ST_AWAIT: begin
        avg_d   = 24'(prod_q >> 35);
        state_d = ST_SEV;
      end
      ST_SEV: begin
        if (drift_q > peak_q) begin
          peak_d = drift_q;
        end
        phase_d = (phase_q >= tpq_q) ? 7'd0 : phase_q + 7'd1;
        last_d  = t_q;
        if (drift_q > limit_q) begin
          alarm_d = 1'b1;
          if (limit_q == 24'd0) begin
            sev_d   = mctt_pkg::SEV_CAP;
            state_d = ST_FIN;
          end else begin
            mul_a   = {8'd0, drift_q};
            mul_b   = 32'd5;
            state_d = ST_SDIV;
          end
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_SDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_q << 8;
        div_req.divisor  = {40'd0, limit_q};
        state_d          = ST_SWAIT;
      end
      ST_SWAIT: begin
        if (div_rsp.done) begin
          sev_d   = (quo > 64'(mctt_pkg::SEV_CAP)) ? mctt_pkg::SEV_CAP : quo[11:0];
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tpq_q       <= 7'd24;
      smooth_q    <= 1'b1;
      factor_q    <= 16'd6554;
      limit_q     <= 24'd5000;
      last_q      <= '0;
      phase_q     <= '0;
      tempo_q     <= mctt_pkg::TEMPO_RESET;
      var_q       <= '0;
      avg_q       <= '0;
      peak_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tpq_q       <= tpq_d;
      smooth_q    <= smooth_d;
      factor_q    <= factor_d;
      limit_q     <= limit_d;
      last_q      <= last_d;
      phase_q     <= phase_d;
      tempo_q     <= tempo_d;
      var_q       <= var_d;
      avg_q       <= avg_d;
      peak_q      <= peak_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q      <= t_d;
    meas_q   <= meas_d;
    raw_q    <= raw_d;
    drift_q  <= drift_d;
    alarm_q  <= alarm_d;
    sev_q    <= sev_d;
    acc_q    <= acc_d;
    sq_q     <= sq_d;
    dsq_q    <= dsq_d;
    prod_q   <= prod_d;
    vhi_q    <= vhi_d;
    vcarry_q <= vcarry_d;
    if (out_load) begin
      o_meas_q  <= meas_q;
      o_raw_q   <= raw_q;
      o_tempo_q <= tempo_q;
      o_drift_q <= drift_q;
      o_avg_q   <= avg_q;
      o_peak_q  <= peak_q;
      o_var_q   <= var_q;
      o_count_q <= count_q;
      o_alarm_q <= alarm_q;
      o_sev_q   <= sev_q;
    end
  end

  assign in_stall_o          = state_q != ST_IDLE;
  assign out_valid_o         = out_valid_q;
  assign measured_o          = o_meas_q;
  assign raw_tempo_q8_o      = o_raw_q;
  assign tempo_q8_o          = o_tempo_q;
  assign drift_us_o          = o_drift_q;
  assign average_drift_us_o  = o_avg_q;
  assign peak_drift_us_o     = o_peak_q;
  assign tempo_variance_q8_o = o_var_q;
  assign measured_count_o    = o_count_q;
  assign drift_alarm_o       = o_alarm_q;
  assign severity_q8_o       = o_sev_q;

endmodule

[hw/rtl/mctt_div.sv]
// ----------------------------------------------------------------------------
// Serial divider
// Restoring 64-bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mctt_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mctt_pkg::div_req_t req_i,
  output mctt_pkg::div_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [63:0] den_q, den_d;
  logic [64:0] trial;
  logic        fits;

  assign trial = {rem_q, quo_q[63]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      den_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? 64'(trial - {1'b0, den_q}) : trial[63:0];
      quo_d = {quo_q[62:0], fits};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
